[src/timed_event_table_macros.svh]
// ---------------------------------------------------------------------------
// timed_event_table assertion macros
// Concurrent check wrappers; they expand to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TIMED_EVENT_TABLE_MACROS_SVH
`define TIMED_EVENT_TABLE_MACROS_SVH

`ifndef SYNTH
// Clocked check, switched off while reset is asserted
`define TET_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset
`define TET_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TET_ASSERT_RST(lbl, clk, rst, prop, msg)
`define TET_ASSERT(lbl, clk, prop, msg)
`endif

`endif

[src/tet_pkg.sv]
// ---------------------------------------------------------------------------
// tet_pkg
// Shared types and constants of the timed event table.
// ---------------------------------------------------------------------------
package tet_pkg;

  localparam int NUM_SLOTS_DEFAULT = 16;
  localparam int MAX_FIRES         = 16;
  localparam int FIRE_CNT_W        = 5;
  localparam int TIME_W            = 32;
  localparam int ID_W              = 8;
  localparam int SLOT_W            = 4;

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_CHECK    = 2'd1,
    CMD_CANCEL   = 2'd2,
    CMD_UNUSED   = 2'd3
  } tet_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } tet_state_t;

  typedef struct packed {
    tet_cmd_t            command;
    logic [TIME_W-1:0]   now_ms;
    logic [TIME_W-1:0]   lead_ms;
    logic [TIME_W-1:0]   interval_ms;
    logic [ID_W-1:0]     event_id;
  } tet_req_t;

  typedef struct packed {
    logic              ok;
    logic              fired;
    logic [ID_W-1:0]   fired_id;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } tet_resp_t;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic [TIME_W-1:0] trigger;
    logic [TIME_W-1:0] interval;
    logic [ID_W-1:0]   event_id;
  } tet_entry_t;

  // Write-back control from the sequencer to the slot store
  typedef struct packed {
    logic mem_we;
    logic set_active;
    logic clr_active;
  } tet_wr_t;

endpackage

[src/timed_event_table.sv]
// ---------------------------------------------------------------------------
// timed_event_table
// Table of timed one-shot and periodic events driven by commands.
// ---------------------------------------------------------------------------
//
//   channel   | handshake            | word
//   ----------+----------------------+-------------------------------------
//   command   | start / busy         | request  (command, times, event id)
//   result    | done (one-cycle)     | response (ok, fired, id, slot, last)
//
// Scan: every command walks the slots one per cycle through the slot
//   memory's single read port (schedule and cancel stop at the first hit,
//   a check ends in a closing state). Schedule, cancel and unused-command
//   words appear in the cycle after their slot is evaluated; a check holds
//   each fire back until the next fire or its closing state, so that the
//   final word carries last.
// Reset: rst clears the active and written flags at once; no clearing pass.
// Stalls: the receiver cannot hold results off; start is ignored while busy.
//
`include "timed_event_table_macros.svh"

module timed_event_table #(
  parameter int NUM_SLOTS = tet_pkg::NUM_SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tet_pkg::tet_req_t  request,
  output logic               busy,
  output logic               done,
  output tet_pkg::tet_resp_t response
);
  import tet_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_active;
  tet_entry_t       rd_entry;
  tet_wr_t          wr;
  logic [IDX_W-1:0] wr_idx;
  tet_entry_t       wr_entry;
  logic             emit;
  tet_resp_t        emit_res;

  // Scan sequencer: reads one slot per cycle and writes it back after a look
  tet_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_idx    (rd_idx),
    .rd_active (rd_active),
    .rd_entry  (rd_entry),
    .wr        (wr),
    .wr_idx    (wr_idx),
    .wr_entry  (wr_entry),
    .emit      (emit),
    .emit_res  (emit_res)
  );

  // Slot memory and flags
  tet_store #(.NUM_SLOTS(NUM_SLOTS)) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_idx    (rd_idx),
    .rd_active (rd_active),
    .rd_entry  (rd_entry),
    .wr        (wr),
    .wr_idx    (wr_idx),
    .wr_entry  (wr_entry)
  );

  // Register each result word onto the ports for exactly one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      response <= emit_res;
    end
  end

  // A taken command keeps the block busy in the next cycle
  `TET_ASSERT_RST(a_accept_busy, clk, rst, (start && !busy) |=> busy, "busy not raised")
  // The closing word of a command is never directly followed by another word
  `TET_ASSERT_RST(a_last_gap, clk, rst, (done && response.last) |=> !done, "word after last")

endmodule

[src/tet_store.sv]
// ---------------------------------------------------------------------------
// tet_store
// Slot memory with a registered read, plus active and written flags.
// ---------------------------------------------------------------------------
module tet_store #(
  parameter int  NUM_SLOTS = tet_pkg::NUM_SLOTS_DEFAULT,
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic                rd_active,
  output tet_pkg::tet_entry_t rd_entry,
  input  tet_pkg::tet_wr_t    wr,
  input  logic [IDX_W-1:0]    wr_idx,
  input  tet_pkg::tet_entry_t wr_entry
);
  import tet_pkg::*;

  tet_entry_t           mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] written;
  tet_entry_t           rd_raw;
  logic                 rd_written;

  always_ff @(posedge clk) begin
    if (wr.mem_we) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_raw     <= mem[rd_idx];
      rd_active  <= active[rd_idx];
      rd_written <= written[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= '0;
      written <= '0;
    end else begin
      if (wr.set_active) begin
        active[wr_idx]  <= 1'b1;
        written[wr_idx] <= 1'b1;
      end else if (wr.clr_active) begin
        active[wr_idx] <= 1'b0;
      end
    end
  end

  // An entry never scheduled reads with id zero
  always_comb begin
    rd_entry          = rd_raw;
    rd_entry.event_id = rd_written ? rd_raw.event_id : '0;
  end

endmodule

[src/tet_ctrl.sv]
// ---------------------------------------------------------------------------
// tet_ctrl
// Slot scan sequencer: issues reads, evaluates each slot and writes back.
// ---------------------------------------------------------------------------
`include "timed_event_table_macros.svh"

module tet_ctrl #(
  parameter int  NUM_SLOTS = tet_pkg::NUM_SLOTS_DEFAULT,
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tet_pkg::tet_req_t   request,
  output logic                busy,
  output logic                rd_en,
  output logic [IDX_W-1:0]    rd_idx,
  input  logic                rd_active,
  input  tet_pkg::tet_entry_t rd_entry,
  output tet_pkg::tet_wr_t    wr,
  output logic [IDX_W-1:0]    wr_idx,
  output tet_pkg::tet_entry_t wr_entry,
  output logic                emit,
  output tet_pkg::tet_resp_t  emit_res
);
  import tet_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  tet_state_t             state, state_next;
  tet_req_t               req;
  logic [TIME_W-1:0]      sched_trig;
  logic                   rd_done;
  logic                   ev_valid;
  logic [IDX_W-1:0]       ev_idx;
  logic [FIRE_CNT_W-1:0]  fire_cnt;
  logic                   pend_valid;
  logic [ID_W-1:0]        pend_id;
  logic [SLOT_W-1:0]      pend_slot;

  logic accept, eval_go, ev_last, due, id_match, fire, finish;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);
  assign rd_en  = (state == ST_SCAN) && !rd_done;
  assign wr_idx = ev_idx;

  // Slot decode
  always_comb begin
    eval_go  = (state == ST_SCAN) && ev_valid;
    ev_last  = (ev_idx == LAST_IDX);
    due      = rd_active && (req.now_ms >= rd_entry.trigger);
    id_match = (rd_entry.event_id == req.event_id);
    fire     = eval_go && (req.command == CMD_CHECK) && due;
    finish   = 1'b0;
    if (eval_go) begin
      case (req.command)
        CMD_SCHEDULE: finish = !rd_active || ev_last;
        CMD_CHECK:    finish = ev_last ||
                               (fire && (fire_cnt == FIRE_CNT_W'(MAX_FIRES - 1)));
        CMD_CANCEL:   finish = id_match || ev_last;
        default:      finish = 1'b1;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (finish) state_next = (req.command == CMD_CHECK) ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs: results and write-back
  always_comb begin
    emit     = 1'b0;
    emit_res = '0;
    wr       = '0;
    wr_entry = rd_entry;
    case (state)
      ST_SCAN: begin
        if (eval_go) begin
          case (req.command)
            CMD_SCHEDULE: begin
              if (!rd_active) begin
                wr.mem_we         = 1'b1;
                wr.set_active     = 1'b1;
                wr_entry.trigger  = sched_trig;
                wr_entry.interval = req.interval_ms;
                wr_entry.event_id = req.event_id;
                emit              = 1'b1;
                emit_res.ok       = 1'b1;
                emit_res.fired_id = req.event_id;
                emit_res.slot     = SLOT_W'(ev_idx);
                emit_res.last     = 1'b1;
              end else if (ev_last) begin
                emit          = 1'b1;
                emit_res.last = 1'b1;
              end
            end
            CMD_CHECK: begin
              if (due) begin
                if (rd_entry.interval != '0) begin
                  wr.mem_we        = 1'b1;
                  wr_entry.trigger = rd_entry.trigger + rd_entry.interval;
                end else begin
                  wr.clr_active = 1'b1;
                end
                // Release the previous fire now that a later one exists
                if (pend_valid) begin
                  emit              = 1'b1;
                  emit_res.ok       = 1'b1;
                  emit_res.fired    = 1'b1;
                  emit_res.fired_id = pend_id;
                  emit_res.slot     = pend_slot;
                end
              end
            end
            CMD_CANCEL: begin
              if (id_match) begin
                wr.clr_active = 1'b1;
                emit          = 1'b1;
                emit_res.ok   = 1'b1;
                emit_res.slot = SLOT_W'(ev_idx);
                emit_res.last = 1'b1;
              end else if (ev_last) begin
                emit          = 1'b1;
                emit_res.last = 1'b1;
              end
            end
            default: begin
              emit          = 1'b1;
              emit_res.last = 1'b1;
            end
          endcase
        end
      end
      ST_FINISH: begin
        emit          = 1'b1;
        emit_res.ok   = 1'b1;
        emit_res.last = 1'b1;
        if (pend_valid) begin
          emit_res.fired    = 1'b1;
          emit_res.fired_id = pend_id;
          emit_res.slot     = pend_slot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_done    <= 1'b0;
      ev_valid   <= 1'b0;
      fire_cnt   <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        rd_done    <= 1'b0;
        ev_valid   <= 1'b0;
        fire_cnt   <= '0;
        pend_valid <= 1'b0;
      end else begin
        ev_valid <= rd_en;
        if (rd_en && (rd_idx == LAST_IDX)) rd_done <= 1'b1;
        if (fire) begin
          pend_valid <= 1'b1;
          fire_cnt   <= fire_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req        <= request;
      sched_trig <= request.now_ms + request.lead_ms;
      rd_idx     <= '0;
    end else if (rd_en && (rd_idx != LAST_IDX)) begin
      rd_idx <= rd_idx + 1'b1;
    end
    if (rd_en) ev_idx <= rd_idx;
    if (fire) begin
      pend_id   <= rd_entry.event_id;
      pend_slot <= SLOT_W'(ev_idx);
    end
  end

  `TET_ASSERT_RST(a_emit_busy, clk, rst, emit |-> (state != ST_IDLE), "result outside a command")
  `TET_ASSERT_RST(a_fire_cap, clk, rst, fire_cnt <= FIRE_CNT_W'(MAX_FIRES), "fire count overrun")
  `TET_ASSERT_RST(a_pend_check, clk, rst, pend_valid |-> (req.command == CMD_CHECK), "pending fire outside check")

endmodule
